// File: rtl/ackrto_pkg.sv
`default_nettype none
package ackrto_pkg;

  localparam int FIELD_W   = 48;
  localparam int LABEL_W   = 32;
  localparam int CFG_IDX_W = 3;
  localparam int THRESH_W  = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_RTO            = 3'd0,
    CFG_FLOW_LEN           = 3'd1,
    CFG_PLB_ENABLE         = 3'd2,
    CFG_ECN_THRESHOLD      = 3'd3,
    CFG_REBALANCE_INTERVAL = 3'd4
  } cfg_idx_t;

  localparam logic [FIELD_W-1:0]  MIN_RTO_RESET   = 48'd2000000;
  localparam logic [FIELD_W-1:0]  FLOW_LEN_RESET  = 48'hFFFF_FFFF_FFFF;
  localparam logic [THRESH_W-1:0] ECN_THR_RESET   = 4'd5;
  localparam logic [FIELD_W-1:0]  REBAL_RESET     = 48'd100000000;

  // one millisecond and one second in picoseconds
  localparam logic [63:0] RTO_RESET_PS    = 64'd1000000000;
  localparam logic [63:0] ACTIVE_RESET_PS = 64'd1000000000000;
  localparam int          ACTIVE_MIN_W    = 40;

endpackage
`default_nettype wire

// File: rtl/ackrto_in_if.sv
`default_nettype none
interface ackrto_in_if;
  logic                              valid;
  logic                              ready;
  logic [ackrto_pkg::FIELD_W-1:0]    arrival_time;
  logic [ackrto_pkg::FIELD_W-1:0]    echo_time;
  logic [ackrto_pkg::FIELD_W-1:0]    ack_seq;
  logic [ackrto_pkg::FIELD_W-1:0]    cum_bytes;
  logic                              ce_mark;
  logic [ackrto_pkg::FIELD_W-1:0]    sent_seq;

  modport source (output valid, arrival_time, echo_time, ack_seq, cum_bytes, ce_mark,
                  sent_seq, input ready);
  modport sink (input valid, arrival_time, echo_time, ack_seq, cum_bytes, ce_mark,
                sent_seq, output ready);
endinterface
`default_nettype wire

// File: rtl/ackrto_out_if.sv
`default_nettype none
interface ackrto_out_if;
  logic                              valid;
  logic                              ready;
  logic [ackrto_pkg::FIELD_W-1:0]    timeout_value;
  logic [ackrto_pkg::FIELD_W-1:0]    smoothed_delay;
  logic [ackrto_pkg::FIELD_W-1:0]    in_flight;
  logic [ackrto_pkg::FIELD_W-1:0]    lost_estimate;
  logic                              flow_done;
  logic                              path_moved;
  logic [ackrto_pkg::LABEL_W-1:0]    path_label;

  modport source (output valid, timeout_value, smoothed_delay, in_flight, lost_estimate,
                  flow_done, path_moved, path_label, input ready);
  modport sink (input valid, timeout_value, smoothed_delay, in_flight, lost_estimate,
                flow_done, path_moved, path_label, output ready);
endinterface
`default_nettype wire

// File: rtl/ackrto_cfg_if.sv
`default_nettype none
interface ackrto_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [ackrto_pkg::CFG_IDX_W-1:0]  index;
  logic [ackrto_pkg::FIELD_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// File: rtl/ackrto_rtt.sv
`default_nettype none
module ackrto_rtt #(
  parameter int TIME_BITS = 48
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 en,
  input  wire logic [TIME_BITS-1:0] delay,
  input  wire logic [TIME_BITS-1:0] min_rto,
  output logic      [TIME_BITS-1:0] srtt_next,
  output logic      [TIME_BITS-1:0] rto_next
);

  localparam logic [TIME_BITS-1:0] TMAX = '1;
  localparam logic [TIME_BITS-1:0] DEV4_LIMIT = TMAX >> 2;

  logic [TIME_BITS-1:0] srtt;
  logic [TIME_BITS-1:0] rtt_dev;
  logic [TIME_BITS-1:0] rto_reg;

  logic [TIME_BITS-1:0] diff;
  logic [TIME_BITS-1:0] dev_q4;
  logic [TIME_BITS-1:0] srtt_q8;
  logic [3:0]           dev_lo3;
  logic [5:0]           srtt_lo7;
  logic [TIME_BITS-1:0] dev_upd;
  logic [TIME_BITS-1:0] srtt_upd;
  logic [TIME_BITS-1:0] dev_next;
  logic [TIME_BITS-1:0] dev4;
  logic [TIME_BITS:0]   rto_sum;
  logic [TIME_BITS-1:0] rto_raw;
  logic [TIME_BITS-1:0] rto_base;

  always_comb begin
    diff     = (delay > srtt) ? delay - srtt : srtt - delay;
    dev_q4   = rtt_dev >> 2;
    srtt_q8  = srtt >> 3;
    dev_lo3  = {2'b00, rtt_dev[1:0]} + {1'b0, rtt_dev[1:0], 1'b0};
    srtt_lo7 = {srtt[2:0], 3'b000} - {3'b000, srtt[2:0]};
    // floor(3*dev/4) + diff/4 and floor(7*srtt/8) + delay/8, without overflow
    dev_upd  = (dev_q4 << 1) + dev_q4 + TIME_BITS'(dev_lo3[3:2]) + (diff >> 2);
    srtt_upd = (srtt_q8 << 3) - srtt_q8 + TIME_BITS'(srtt_lo7[5:3]) + (delay >> 3);

    if (delay == '0) begin
      srtt_next = srtt;
      dev_next  = rtt_dev;
    end else if (srtt != '0) begin
      srtt_next = srtt_upd;
      dev_next  = dev_upd;
    end else begin
      // first sample
      srtt_next = delay;
      dev_next  = delay >> 1;
    end

    dev4     = (dev_next > DEV4_LIMIT) ? TMAX : (dev_next << 2);
    rto_sum  = {1'b0, srtt_next} + {1'b0, dev4};
    rto_raw  = rto_sum[TIME_BITS] ? TMAX : rto_sum[TIME_BITS-1:0];
    rto_base = (delay != '0) ? rto_raw : rto_reg;
    rto_next = (rto_base < min_rto) ? min_rto : rto_base;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      srtt    <= '0;
      rtt_dev <= '0;
      rto_reg <= TIME_BITS'(ackrto_pkg::RTO_RESET_PS);
    end else if (en) begin
      srtt    <= srtt_next;
      rtt_dev <= dev_next;
      rto_reg <= rto_next;
    end
  end

endmodule
`default_nettype wire

// File: rtl/ack_rto_and_path_rebalance.sv
`default_nettype none
// Results pass through the input register and then the result register; a stalled output holds them.
// Throughput: one ack per cycle while the result is not stalled; all state updates in the single stage
// between the input register and the result register.
// Reset (rst, synchronous): clears pipeline valids, RTT/path state and config to defaults.
// A stalled result holds the result register, then the input register; ready drops when both are full.
module ack_rto_and_path_rebalance #(
  parameter int MARK_WINDOW = 10,
  parameter int TIME_BITS   = 48
) (
  input  wire logic         clk,
  input  wire logic         rst,
  ackrto_in_if.sink         ack,
  ackrto_out_if.source      res,
  ackrto_cfg_if.sink        cfg
);

  localparam int FW = ackrto_pkg::FIELD_W;
  localparam int LW = ackrto_pkg::LABEL_W;
  localparam int TW = ackrto_pkg::THRESH_W;
  localparam int CW = $clog2(MARK_WINDOW + 1);
  localparam int KW = (CW > TW) ? CW : TW;
  localparam int AW = (TIME_BITS > ackrto_pkg::ACTIVE_MIN_W) ? TIME_BITS
                                                               : ackrto_pkg::ACTIVE_MIN_W;
  localparam logic [TIME_BITS-1:0] TMAX = '1;
  localparam logic [TIME_BITS-1:0] TDIV10 = TMAX / 10;

  // configuration
  logic [FW-1:0] min_rto;
  logic [FW-1:0] flow_len;
  logic          plb_enable;
  logic [TW-1:0] ecn_threshold;
  logic [FW-1:0] rebalance_interval;

  // input register
  logic                 s1_valid;
  logic [TIME_BITS-1:0] s1_now;
  logic [TIME_BITS-1:0] s1_echo;
  logic [FW-1:0]        s1_aseq;
  logic [FW-1:0]        s1_cum;
  logic                 s1_mark;
  logic [FW-1:0]        s1_sent;

  // flow and path state
  logic [FW-1:0]          acked_bytes;
  logic [FW-1:0]          highest_ack;
  logic                   done_flag;
  logic [MARK_WINDOW-1:0] mark_window;
  logic [CW-1:0]          mark_cnt;
  logic [TIME_BITS-1:0]   good_time;
  logic [AW-1:0]          active_interval;
  logic [LW-1:0]          label_reg;

  // result register
  logic          res_valid;
  logic [FW-1:0] res_timeout;
  logic [FW-1:0] res_srtt;
  logic [FW-1:0] res_inflight;
  logic [FW-1:0] res_lost;
  logic          res_done;
  logic          res_moved;
  logic [LW-1:0] res_label;

  logic out_free;
  logic adv;
  logic ack_fire;

  logic [TIME_BITS-1:0]   delay;
  logic [TIME_BITS-1:0]   min_rto_t;
  logic [TIME_BITS-1:0]   srtt_next;
  logic [TIME_BITS-1:0]   rto_next;
  logic [FW-1:0]          acked_bytes_next;
  logic [FW-1:0]          highest_ack_next;
  logic [FW-1:0]          inflight;
  logic [FW-1:0]          hi_m1;
  logic [FW-1:0]          lost;
  logic                   done_next;
  logic [MARK_WINDOW-1:0] mark_window_next;
  logic [CW-1:0]          mark_cnt_next;
  logic                   good;
  logic [TIME_BITS-1:0]   ten;
  logic [TIME_BITS-1:0]   ten_x10;
  logic [TIME_BITS-1:0]   since_good;
  logic                   move;

  assign out_free  = !res_valid || res.ready;
  assign adv       = s1_valid && out_free;
  assign ack.ready = !s1_valid || out_free;
  assign ack_fire  = ack.valid && ack.ready;
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_rto            <= ackrto_pkg::MIN_RTO_RESET;
      flow_len           <= ackrto_pkg::FLOW_LEN_RESET;
      plb_enable         <= 1'b0;
      ecn_threshold      <= ackrto_pkg::ECN_THR_RESET;
      rebalance_interval <= ackrto_pkg::REBAL_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        ackrto_pkg::CFG_MIN_RTO:            min_rto            <= cfg.data;
        ackrto_pkg::CFG_FLOW_LEN:           flow_len           <= cfg.data;
        ackrto_pkg::CFG_PLB_ENABLE:         plb_enable         <= cfg.data[0];
        ackrto_pkg::CFG_ECN_THRESHOLD:      ecn_threshold      <= cfg.data[TW-1:0];
        ackrto_pkg::CFG_REBALANCE_INTERVAL: rebalance_interval <= cfg.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (ack_fire) begin
      s1_valid <= 1'b1;
    end else if (adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ack_fire) begin
      s1_now  <= TIME_BITS'(ack.arrival_time);
      s1_echo <= TIME_BITS'(ack.echo_time);
      s1_aseq <= ack.ack_seq;
      s1_cum  <= ack.cum_bytes;
      s1_mark <= ack.ce_mark;
      s1_sent <= ack.sent_seq;
    end
  end

  assign delay     = s1_now - s1_echo;
  assign min_rto_t = TIME_BITS'(min_rto);

  ackrto_rtt #(
    .TIME_BITS (TIME_BITS)
  ) u_rtt (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .delay     (delay),
    .min_rto   (min_rto_t),
    .srtt_next (srtt_next),
    .rto_next  (rto_next)
  );

  always_comb begin
    acked_bytes_next = (s1_cum > acked_bytes) ? s1_cum : acked_bytes;
    highest_ack_next = (s1_aseq > highest_ack) ? s1_aseq : highest_ack;
    inflight         = (s1_sent > highest_ack_next) ? s1_sent - highest_ack_next : '0;
    hi_m1            = highest_ack_next - FW'(1);
    lost             = (highest_ack_next != '0 && hi_m1 > acked_bytes_next)
                       ? hi_m1 - acked_bytes_next : '0;
    done_next        = done_flag || (acked_bytes_next >= flow_len);

    // the running count tracks the window: add the new mark, drop the oldest
    mark_window_next = MARK_WINDOW'({mark_window, s1_mark});
    mark_cnt_next    = mark_cnt + CW'(s1_mark) - CW'(mark_window[MARK_WINDOW-1]);
    good             = KW'(mark_cnt_next) < KW'(ecn_threshold);

    ten        = TIME_BITS'(rebalance_interval);
    ten_x10    = (ten > TDIV10) ? TMAX : (ten << 3) + (ten << 1);
    since_good = s1_now - good_time;
    // a good ack resets the timer, so only a bad one can move the path
    move       = plb_enable && !good && (AW'(since_good) > active_interval);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acked_bytes     <= '0;
      highest_ack     <= '0;
      done_flag       <= 1'b0;
      mark_window     <= '0;
      mark_cnt        <= '0;
      good_time       <= '0;
      active_interval <= AW'(ackrto_pkg::ACTIVE_RESET_PS);
      label_reg       <= '0;
    end else if (adv) begin
      acked_bytes <= acked_bytes_next;
      highest_ack <= highest_ack_next;
      done_flag   <= done_next;
      if (plb_enable) begin
        mark_window <= mark_window_next;
        mark_cnt    <= mark_cnt_next;
        if (good) begin
          good_time       <= s1_now;
          active_interval <= AW'(ten_x10);
        end
        if (move) begin
          good_time <= s1_now;
          label_reg <= label_reg + LW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= 1'b1;
    end else if (res.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      res_timeout  <= FW'(rto_next);
      res_srtt     <= FW'(srtt_next);
      res_inflight <= inflight;
      res_lost     <= lost;
      res_done     <= done_next;
      res_moved    <= move;
      res_label    <= move ? label_reg + LW'(1) : label_reg;
    end
  end

  assign res.valid          = res_valid;
  assign res.timeout_value  = res_timeout;
  assign res.smoothed_delay = res_srtt;
  assign res.in_flight      = res_inflight;
  assign res.lost_estimate  = res_lost;
  assign res.flow_done      = res_done;
  assign res.path_moved     = res_moved;
  assign res.path_label     = res_label;

`ifndef SYNTHESIS
  a_label_step: assert property (@(posedge clk) disable iff (rst)
    adv |=> (label_reg == $past(label_reg) + LW'($past(move))))
    else $error("path label did not follow the move decision");

  a_rto_clamp: assert property (@(posedge clk) disable iff (rst)
    adv |-> (rto_next >= min_rto_t))
    else $error("timeout below minimum");

  a_mark_count: assert property (@(posedge clk) disable iff (rst)
    mark_cnt == CW'($countones(mark_window)))
    else $error("mark count out of step with window");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_free) |=> (s1_valid && $stable(s1_now) && $stable(s1_aseq)))
    else $error("stalled item lost from input register");
`endif

endmodule
`default_nettype wire
